FILE: hdl/gdr_pkg.sv
// Shared types, constants and calendar functions for the Gregorian date register.
`timescale 1ns / 1ps
`default_nettype none
package gdr_pkg;

	localparam int YEAR_W  = 12;
	localparam int EPOCH_W = 20;
	localparam int ACC_W   = EPOCH_W + 1;

	localparam logic [YEAR_W-1:0] FIRST_YEAR   = 12'd1970;
	localparam logic [2:0]        WEEKDAY_BASE = 3'd3;

	// floor(x / 7) = (x * RECIP7) >> RECIP7_SHIFT, exact for x < 2**21
	localparam logic [20:0] RECIP7       = 21'd1198373;
	localparam int          RECIP7_SHIFT = 23;
	localparam int          QUOT7_W      = 19;

	typedef enum logic [2:0] {
		KIND_QUERY,
		KIND_SET_DATE,
		KIND_SET_DAY,
		KIND_SET_MONTH,
		KIND_SET_YEAR,
		KIND_ADD_DAYS,
		KIND_SET_EPOCH,
		KIND_NONE
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TO_Y,
		ST_TO_M,
		ST_FROM_Y,
		ST_FROM_M,
		ST_WDAY,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [4:0]         day_in;
		logic [3:0]         month_in;
		logic [YEAR_W-1:0]  year_in;
		logic [EPOCH_W-1:0] day_count;
	} in_t;

	typedef struct packed {
		logic               ok;
		logic [4:0]         day_out;
		logic [3:0]         month_out;
		logic [YEAR_W-1:0]  year_out;
		logic [EPOCH_W-1:0] epoch_days;
		logic [2:0]         weekday;
	} out_t;

	// sequencer -> datapath
	typedef struct packed {
		logic load;
		logic check;
		logic month_ph;
		logic sub_ph;
		logic to_init;
		logic yr_step;
		logic mo_step;
		logic to_done;
		logic from_init;
		logic fy_step;
		logic fm_step;
		logic commit;
		logic reject;
		logic wday;
		logic wr_out;
	} ctrl_t;

	// datapath -> sequencer
	typedef struct packed {
		kind_t kind;
		logic  yr_more;
		logic  mo_more;
		logic  fit;
		logic  fy_over;
		logic  from_done;
		logic  out_free;
	} stat_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [24:0]       p;
		logic [5:0]        q;
		logic [YEAR_W-1:0] r;
		p = y * 13'd5243;
		q = p[24:19];
		r = y - (YEAR_W'(q) * 12'd100);
		return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m) inside
			4'd2: n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/gregorian_date_register.sv
// Top level of the Gregorian date register.
`timescale 1ns / 1ps
`default_nettype none
// Holds one date (1 Jan 1970 after reset) and takes one command beat at a time: query, set the
// date or one field of it, add days, or load a day count since 1970. Each beat returns one
// result with ok, the date, days since 1970 and the weekday (0 Monday). The block walks the
// calendar with one shared adder, one year or one month per cycle. A query, a set or an unused
// kind walks up from 1970 to the date held after the command. Load day count first walks down
// to the new date; add days also walks up to the old date first. A day count past LAST_YEAR
// walks every year through LAST_YEAR before it is rejected. in_ready is high only between
// commands; a finished result waits in the output register, and only the following result
// stalls on it.
module gregorian_date_register #(
	parameter int LAST_YEAR = 2099
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire gdr_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output gdr_pkg::out_t      out_data
);

	gdr_pkg::ctrl_t ctrl;
	gdr_pkg::stat_t stat;

	gdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	gdr_dp #(
		.LAST_YEAR (LAST_YEAR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a beat while busy");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.month_out >= 4'd1 && out_data.month_out <= 4'd12 &&
			out_data.day_out >= 5'd1 && out_data.year_out >= gdr_pkg::FIRST_YEAR &&
			{1'b0, out_data.year_out} <= 13'(LAST_YEAR))
		else $error("reported date out of range");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.weekday <= 3'd6)
		else $error("weekday out of range");

endmodule
`default_nettype wire

FILE: hdl/gdr_ctrl.sv
// Sequencer for the date register: steps the shared add/subtract unit through the walks.
`timescale 1ns / 1ps
`default_nettype none
module gdr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire gdr_pkg::stat_t stat,
	output gdr_pkg::ctrl_t      ctrl
);

	gdr_pkg::state_t state_q;
	gdr_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gdr_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = gdr_pkg::ST_CHECK;
			end
			gdr_pkg::ST_CHECK: begin
				if (stat.kind == gdr_pkg::KIND_SET_EPOCH) state_nxt = gdr_pkg::ST_FROM_Y;
				else state_nxt = gdr_pkg::ST_TO_Y;
			end
			gdr_pkg::ST_TO_Y: begin
				if (!stat.yr_more) state_nxt = gdr_pkg::ST_TO_M;
			end
			gdr_pkg::ST_TO_M: begin
				if (!stat.mo_more) begin
					if (stat.kind == gdr_pkg::KIND_ADD_DAYS && !stat.from_done)
						state_nxt = gdr_pkg::ST_FROM_Y;
					else
						state_nxt = gdr_pkg::ST_WDAY;
				end
			end
			gdr_pkg::ST_FROM_Y: begin
				if (stat.fy_over) state_nxt = gdr_pkg::ST_TO_Y;
				else if (!stat.fit) state_nxt = gdr_pkg::ST_FROM_M;
			end
			gdr_pkg::ST_FROM_M: begin
				if (!stat.fit) state_nxt = gdr_pkg::ST_TO_Y;
			end
			gdr_pkg::ST_WDAY: begin
				state_nxt = gdr_pkg::ST_DONE;
			end
			gdr_pkg::ST_DONE: begin
				if (stat.out_free) state_nxt = gdr_pkg::ST_IDLE;
			end
			default: state_nxt = gdr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gdr_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			gdr_pkg::ST_CHECK: begin
				ctrl.check = 1'b1;
				if (stat.kind == gdr_pkg::KIND_SET_EPOCH) ctrl.from_init = 1'b1;
				else ctrl.to_init = 1'b1;
			end
			gdr_pkg::ST_TO_Y: begin
				ctrl.yr_step = stat.yr_more;
			end
			gdr_pkg::ST_TO_M: begin
				ctrl.month_ph = 1'b1;
				ctrl.mo_step  = stat.mo_more;
				ctrl.to_done  = !stat.mo_more;
				ctrl.from_init = !stat.mo_more && !stat.from_done &&
					(stat.kind == gdr_pkg::KIND_ADD_DAYS);
			end
			gdr_pkg::ST_FROM_Y: begin
				ctrl.sub_ph = 1'b1;
				if (stat.fy_over) begin
					ctrl.reject  = 1'b1;
					ctrl.to_init = 1'b1;
				end else begin
					ctrl.fy_step = stat.fit;
				end
			end
			gdr_pkg::ST_FROM_M: begin
				ctrl.month_ph = 1'b1;
				ctrl.sub_ph   = 1'b1;
				ctrl.fm_step  = stat.fit;
				ctrl.commit   = !stat.fit;
				ctrl.to_init  = !stat.fit;
			end
			gdr_pkg::ST_WDAY: begin
				ctrl.wday = 1'b1;
			end
			gdr_pkg::ST_DONE: begin
				ctrl.wr_out = stat.out_free;
			end
			default: ctrl = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/gdr_dp.sv
// Datapath: stored date, shared day-count accumulator, weekday reduction and result register.
`timescale 1ns / 1ps
`default_nettype none
module gdr_dp #(
	parameter int LAST_YEAR = 2099
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gdr_pkg::in_t   in_data,
	input  wire gdr_pkg::ctrl_t ctrl,
	output gdr_pkg::stat_t      stat,
	output logic                out_valid,
	input  wire logic           out_ready,
	output gdr_pkg::out_t       out_data
);

	localparam int YW = gdr_pkg::YEAR_W;
	localparam int AW = gdr_pkg::ACC_W;
	localparam logic [YW:0] LAST_Y = (YW+1)'(LAST_YEAR);

	gdr_pkg::in_t in_q;
	logic [4:0]  cur_day_q;
	logic [3:0]  cur_month_q;
	logic [YW-1:0] cur_year_q;
	logic [YW:0] wy_q;
	logic [3:0]  wm_q;
	logic [AW-1:0] acc_q;
	logic [gdr_pkg::EPOCH_W-1:0] e_q;
	logic [gdr_pkg::QUOT7_W-1:0] q7_q;
	logic ok_q;
	logic from_done_q;
	gdr_pkg::out_t out_q;
	logic out_valid_q;

	logic wr_day, wr_month, wr_year, is_set;
	logic [4:0]  cd;
	logic [3:0]  cm;
	logic [YW-1:0] cy;
	logic [YW-1:0] leap_year;
	logic leap;
	logic date_ok;
	logic [8:0] len;
	logic [AW:0] sum;
	logic [AW-1:0] from_src;
	logic [AW-1:0] wx;
	logic [41:0] prod;
	logic [2:0] rem;

	assign wr_day   = (in_q.kind == gdr_pkg::KIND_SET_DATE) || (in_q.kind == gdr_pkg::KIND_SET_DAY);
	assign wr_month = (in_q.kind == gdr_pkg::KIND_SET_DATE) ||
		(in_q.kind == gdr_pkg::KIND_SET_MONTH);
	assign wr_year  = (in_q.kind == gdr_pkg::KIND_SET_DATE) || (in_q.kind == gdr_pkg::KIND_SET_YEAR);
	assign is_set   = wr_day || wr_month || wr_year;

	assign cd = wr_day   ? in_q.day_in   : cur_day_q;
	assign cm = wr_month ? in_q.month_in : cur_month_q;
	assign cy = wr_year  ? in_q.year_in  : cur_year_q;

	// one leap unit, shared by the set check and the walks
	assign leap_year = ctrl.check ? cy : wy_q[YW-1:0];
	assign leap      = gdr_pkg::is_leap(leap_year);

	assign date_ok = (cy >= gdr_pkg::FIRST_YEAR) && ({1'b0, cy} <= LAST_Y) &&
		(cm >= 4'd1) && (cm <= 4'd12) &&
		(cd >= 5'd1) && (cd <= gdr_pkg::month_len(cm, leap));

	// shared add/subtract unit
	assign len = ctrl.month_ph ? 9'(gdr_pkg::month_len(wm_q, leap)) : gdr_pkg::year_len(leap);
	assign sum = ctrl.sub_ph ? ({1'b0, acc_q} - (AW+1)'(len)) : ({1'b0, acc_q} + (AW+1)'(len));

	assign from_src = (in_q.kind == gdr_pkg::KIND_SET_EPOCH) ? AW'(in_q.day_count) :
		AW'(acc_q + AW'(cur_day_q) - AW'(1) + AW'(in_q.day_count));

	assign wx   = AW'(e_q) + AW'(gdr_pkg::WEEKDAY_BASE);
	assign prod = wx * gdr_pkg::RECIP7;
	assign rem  = 3'(wx - ((AW'(q7_q) << 3) - AW'(q7_q)));

	assign stat.kind      = in_q.kind;
	assign stat.yr_more   = wy_q < {1'b0, cur_year_q};
	assign stat.mo_more   = wm_q < cur_month_q;
	assign stat.fit       = !sum[AW];
	assign stat.fy_over   = wy_q > LAST_Y;
	assign stat.from_done = from_done_q;
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= 5'd1;
			cur_month_q <= 4'd1;
			cur_year_q  <= gdr_pkg::FIRST_YEAR;
			from_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.check && is_set && date_ok) begin
				cur_day_q   <= cd;
				cur_month_q <= cm;
				cur_year_q  <= cy;
			end else if (ctrl.commit) begin
				cur_day_q   <= 5'(acc_q + AW'(1));
				cur_month_q <= wm_q;
				cur_year_q  <= wy_q[YW-1:0];
			end
			if (ctrl.load) from_done_q <= 1'b0;
			else if (ctrl.from_init) from_done_q <= 1'b1;
			if (ctrl.wr_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) in_q <= in_data;
		if (ctrl.check) ok_q <= (in_q.kind == gdr_pkg::KIND_QUERY) || (is_set && date_ok);
		else if (ctrl.commit) ok_q <= 1'b1;
		else if (ctrl.reject) ok_q <= 1'b0;
		if (ctrl.to_init || ctrl.from_init) begin
			wy_q <= {1'b0, gdr_pkg::FIRST_YEAR};
			wm_q <= 4'd1;
			acc_q <= ctrl.from_init ? from_src : '0;
		end else if (ctrl.yr_step || ctrl.fy_step) begin
			wy_q  <= wy_q + 1'b1;
			acc_q <= sum[AW-1:0];
		end else if (ctrl.mo_step || ctrl.fm_step) begin
			wm_q  <= wm_q + 4'd1;
			acc_q <= sum[AW-1:0];
		end
		if (ctrl.to_done) e_q <= gdr_pkg::EPOCH_W'(acc_q + AW'(cur_day_q) - AW'(1));
		if (ctrl.wday) q7_q <= gdr_pkg::QUOT7_W'(prod >> gdr_pkg::RECIP7_SHIFT);
		if (ctrl.wr_out) begin
			out_q.ok         <= ok_q;
			out_q.day_out    <= cur_day_q;
			out_q.month_out  <= cur_month_q;
			out_q.year_out   <= cur_year_q;
			out_q.epoch_days <= e_q;
			out_q.weekday    <= rem;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
